// ===== design/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the service flap detector.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 9;
  localparam int REC_W   = STAMP_W + COUNT_W;

  typedef enum logic [0:0] {
    ACT_CHECK  = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    REG_FLAP_LIMIT = 1'b0,
    REG_WINDOW     = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_DISABLED  = 3'd0,
    ST_CREATED   = 3'd1,
    ST_COUNTED   = 3'd2,
    ST_RESTARTED = 3'd3,
    ST_FLAPPING  = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [COUNT_W-1:0] count;
  } slot_rec_t;

endpackage

// ===== design/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/service_flap_detector.sv =====
// ----------------------------------------------------------------------------
// service_flap_detector
// Restart flap detection over a table of service slots.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: raise start with in_action, in_service_index and in_time_now;
//   a request is taken at every edge where start is high and busy is low.
//   busy stays low, so one request can be taken every cycle.
//   Results: out_valid is high for exactly one cycle with out_flapping and
//   out_status; the receiver has no way to hold them off and none is needed.
//   Each request is held in the s1 registers and its result in the output
//   registers; one result per request, in request order, one per cycle
//   sustained.
//   The accepting edge reads the slot record from the stamp/count RAM; the
//   s1 step evaluates the window and limit and writes the record back. A
//   request to the slot just written picks up the new record by forwarding.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 flap limit,
//   1 window seconds) and cfg_data; write only while no request is pending.
//   Reset clears the limit, the window and all slot valid marks at once;
//   stamp and count storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module service_flap_detector
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_service_index,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  output logic        out_flapping,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]         flap_limit_r;
  logic [15:0]        window_r;
  logic [SLOTS-1:0]   slot_valid_r, slot_valid_nxt;

  logic               s1_valid_r;
  logic               s1_action_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic               s1_in_range_r;
  logic [STAMP_W-1:0] s1_now_r;
  logic               fwd_hit_r;
  slot_rec_t          fwd_rec_r;

  logic               out_valid_r;
  logic               out_flapping_r;
  status_t            out_status_r;

  logic               accept;
  logic [IDX_W-1:0]   in_idx;
  logic               in_range;
  logic [REC_W-1:0]   ram_rdata;
  slot_rec_t          rec;
  logic               wr_en;
  slot_rec_t          wr_rec;
  logic               slot_vld;
  logic [STAMP_W-1:0] elapsed;
  logic               in_window;
  logic [COUNT_W-1:0] cnt_inc;
  logic               over;
  logic               flap_nxt;
  status_t            status_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_idx    = IDX_W'(in_service_index);
  assign in_range  = 32'(in_service_index) < 32'(SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flap_limit_r <= '0;
      window_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_FLAP_LIMIT: flap_limit_r <= cfg_data[7:0];
        REG_WINDOW:     window_r     <= cfg_data;
        default:        ;
      endcase
    end
  end

  sfd_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (wr_rec),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r   <= in_action;
      s1_idx_r      <= in_idx;
      s1_in_range_r <= in_range;
      s1_now_r      <= in_time_now;
      fwd_hit_r     <= wr_en && (s1_idx_r == in_idx);
      fwd_rec_r     <= wr_rec;
    end
  end

  assign rec       = fwd_hit_r ? fwd_rec_r : slot_rec_t'(ram_rdata);
  assign slot_vld  = slot_valid_r[s1_idx_r];
  assign elapsed   = s1_now_r - rec.stamp;
  assign in_window = elapsed < STAMP_W'(window_r);
  assign cnt_inc   = rec.count + COUNT_W'(1);
  assign over      = cnt_inc > COUNT_W'(flap_limit_r);

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    wr_en          = 1'b0;
    wr_rec         = rec;
    flap_nxt       = 1'b0;
    status_nxt     = ST_DISABLED;
    if (s1_action_r == ACT_REMOVE) begin
      if (s1_in_range_r && slot_vld) begin
        slot_valid_nxt[s1_idx_r] = s1_valid_r ? 1'b0 : slot_vld;
        status_nxt               = ST_REMOVED;
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end else if (flap_limit_r == '0 || window_r == '0 || !s1_in_range_r) begin
      status_nxt = ST_DISABLED;
    end else if (!slot_vld) begin
      slot_valid_nxt[s1_idx_r] = s1_valid_r;
      wr_en                    = s1_valid_r;
      wr_rec.stamp             = s1_now_r;
      wr_rec.count             = '0;
      status_nxt               = ST_CREATED;
    end else if (in_window) begin
      wr_en        = s1_valid_r;
      wr_rec.count = cnt_inc;
      if (over) begin
        slot_valid_nxt[s1_idx_r] = !s1_valid_r;
        flap_nxt                 = 1'b1;
        status_nxt               = ST_FLAPPING;
      end else begin
        status_nxt = ST_COUNTED;
      end
    end else begin
      wr_en        = s1_valid_r;
      wr_rec.stamp = s1_now_r;
      wr_rec.count = COUNT_W'(1);
      status_nxt   = ST_RESTARTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_flapping_r <= flap_nxt;
      out_status_r   <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_flapping = out_flapping_r;
  assign out_status   = out_status_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("request without result two cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without a request");

  a_flap_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flapping) |-> (out_status == ST_FLAPPING))
    else $error("flapping reported with wrong status");

  a_flap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && flap_nxt) |=> !slot_valid_r[$past(s1_idx_r)])
    else $error("flapping slot still valid");

endmodule

// ===== sim/service_flap_detector_test.sv =====
// ----------------------------------------------------------------------------
// service_flap_detector_test
// Self-checking bench for the service flap detector. A restart tracker keeps
// its own copy of the slot table and the two settings, predicts the answer to
// every accepted request and compares it with the result strobe. A directed
// sequence covers creation, counting, flapping, window restart, removal,
// time wrap and disabled settings; random phases (one led by a restart burst)
// mix checks and removals on a few hot slots, varied settings and idle rates.
// ----------------------------------------------------------------------------
module service_flap_detector_test
  import sfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic    flapping;
    status_t status;
  } flap_answer_t;

  class restart_tracker;
    logic [7:0]  flap_limit;
    logic [15:0] window;
    logic        rec_valid [SLOTS];
    logic [31:0] rec_stamp [SLOTS];
    logic [8:0]  rec_count [SLOTS];
    flap_answer_t expected_answers[$];
    int errors;

    function new();
      flap_limit = '0;
      window     = '0;
      errors     = 0;
      foreach (rec_valid[i]) begin
        rec_valid[i] = 1'b0;
        rec_stamp[i] = '0;
        rec_count[i] = '0;
      end
    endfunction

    function void set_config(logic [7:0] limit, logic [15:0] win);
      flap_limit = limit;
      window     = win;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function void note_request(action_t act, logic [5:0] idx, logic [31:0] now);
      flap_answer_t ans;
      logic [31:0]  elapsed;
      logic [8:0]   cnt;
      ans.flapping = 1'b0;
      if (act == ACT_REMOVE) begin
        if (idx < SLOTS && rec_valid[idx]) begin
          rec_valid[idx] = 1'b0;
          ans.status = ST_REMOVED;
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end else if (flap_limit == 0 || window == 0 || idx >= SLOTS) begin
        ans.status = ST_DISABLED;
      end else if (!rec_valid[idx]) begin
        rec_valid[idx] = 1'b1;
        rec_stamp[idx] = now;
        rec_count[idx] = '0;
        ans.status = ST_CREATED;
      end else begin
        elapsed = now - rec_stamp[idx];
        if (elapsed < {16'h0000, window}) begin
          cnt = rec_count[idx] + 9'd1;
          rec_count[idx] = cnt;
          if (cnt > {1'b0, flap_limit}) begin
            rec_valid[idx] = 1'b0;
            ans.flapping = 1'b1;
            ans.status = ST_FLAPPING;
          end else begin
            ans.status = ST_COUNTED;
          end
        end else begin
          rec_stamp[idx] = now;
          rec_count[idx] = 9'd1;
          ans.status = ST_RESTARTED;
        end
      end
      expected_answers.push_back(ans);
    endfunction

    function void check_result(logic flapping, logic [2:0] status);
      flap_answer_t ans;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: flapping %0b, status %0d", flapping, status);
        errors++;
        return;
      end
      ans = expected_answers.pop_front();
      if (flapping !== ans.flapping) begin
        $error("flapping: expected %0b, actual %0b", ans.flapping, flapping);
        errors++;
      end
      if (status !== ans.status) begin
        $error("status: expected %0d, actual %0d", ans.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = 1'b0;
  logic [5:0]  in_service_index = '0;
  logic [31:0] in_time_now = '0;
  logic        out_valid;
  logic        out_flapping;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  int unsigned cycles = 0;
  restart_tracker tracker = new();

  service_flap_detector u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_service_index (in_service_index),
    .in_time_now      (in_time_now),
    .out_valid        (out_valid),
    .out_flapping     (out_flapping),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      tracker.check_result(out_flapping, out_status);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** service_flap_detector: FAILED **");
      $finish;
    end
  end

  task automatic send_request(action_t act, logic [5:0] idx, logic [31:0] now);
    start            <= 1'b1;
    in_action        <= act;
    in_service_index <= idx;
    in_time_now      <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(act, idx, now);
  endtask

  task automatic pause_requests(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every answer is back, then let the pipeline settle
  task automatic drain_requests();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(logic [7:0] limit, logic [15:0] win);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FLAP_LIMIT;
    cfg_data  <= {8'h00, limit};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_WINDOW;
    cfg_data  <= win;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_config(limit, win);
  endtask

  task automatic run_phase(logic [7:0] limit, logic [15:0] win, int idle_pct,
                           int count, logic [31:0] base, bit burst);
    logic [31:0] now;
    logic [5:0]  hot;
    logic [5:0]  idx;
    action_t     act;
    int unsigned step;
    int          r;
    now = base;
    hot = 6'($urandom_range(0, 60));
    drain_requests();
    write_settings(limit, win);
    if (burst) begin
      send_request(ACT_REMOVE, hot, now);
      for (int i = 0; i <= int'(limit) + 1; i++) begin
        if ($urandom_range(0, 99) < idle_pct) pause_requests($urandom_range(1, 5));
        send_request(ACT_CHECK, hot, now);
      end
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        pause_requests($urandom_range(1, 6));
      end else if ($urandom_range(0, 149) == 0) begin
        drain_requests();
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        step = $urandom_range(0, win / 4 + 1);
      end else if (r < 85) begin
        step = (win > 1) ? $urandom_range(win - 1, win + 1) : $urandom_range(0, 2);
      end else if (r < 95) begin
        step = $urandom;
      end else begin
        step = 0;
      end
      now = now + step;
      idx = ($urandom_range(0, 4) != 0) ? hot + 6'($urandom_range(0, 3))
                                        : 6'($urandom_range(0, 63));
      act = ($urandom_range(0, 99) < 12) ? ACT_REMOVE : ACT_CHECK;
      if ($urandom_range(0, 19) == 0) begin
        send_request(act, idx, $urandom);
      end else begin
        send_request(act, idx, now);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ACT_CHECK,  6'd0, 32'd0);
    send_request(ACT_REMOVE, 6'd0, 32'd0);

    drain_requests();
    write_settings(8'd2, 16'd10);
    send_request(ACT_CHECK,  6'd5,  32'd100);
    send_request(ACT_CHECK,  6'd5,  32'd105);
    send_request(ACT_CHECK,  6'd5,  32'd109);
    send_request(ACT_CHECK,  6'd5,  32'd109);
    send_request(ACT_REMOVE, 6'd5,  32'd110);
    send_request(ACT_CHECK,  6'd5,  32'd200);
    send_request(ACT_CHECK,  6'd5,  32'd210);
    send_request(ACT_REMOVE, 6'd5,  32'd211);
    send_request(ACT_CHECK,  6'd63, 32'hFFFF_FFFA);
    send_request(ACT_CHECK,  6'd63, 32'h0000_0003);
    send_request(ACT_CHECK,  6'd63, 32'hFFFF_FFFF);
    send_request(ACT_CHECK,  6'd9,  32'hFFFF_FFFF);

    drain_requests();
    write_settings(8'd0, 16'd10);
    send_request(ACT_CHECK,  6'd9, 32'd0);
    send_request(ACT_REMOVE, 6'd9, 32'd0);

    drain_requests();
    write_settings(8'd255, 16'd0);
    send_request(ACT_CHECK, 6'd1, 32'd0);

    drain_requests();
    write_settings(8'd255, 16'd65535);
    send_request(ACT_CHECK, 6'd1, 32'd0);
    send_request(ACT_CHECK, 6'd1, 32'd65534);
    send_request(ACT_CHECK, 6'd1, 32'd65535);

    drain_requests();
    write_settings(8'd1, 16'd1);
    send_request(ACT_CHECK, 6'd2, 32'd7);
    send_request(ACT_CHECK, 6'd2, 32'd7);
    send_request(ACT_CHECK, 6'd2, 32'd7);
    send_request(ACT_CHECK, 6'd2, 32'd8);
    send_request(ACT_CHECK, 6'd2, 32'd9);

    run_phase(8'd3,   16'd20,    0,  65, $urandom,        1'b0);
    run_phase(8'd1,   16'd1,     65, 65, $urandom,        1'b0);
    run_phase(8'd255, 16'd65535, 10, 65, 32'hFFFF_F000,   1'b1);
    run_phase(8'd0,   16'd100,   65, 65, $urandom,        1'b0);
    run_phase(8'd7,   16'd0,     0,  65, $urandom,        1'b0);
    run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
              10, 65, $urandom, 1'b0);
    run_phase(8'd2,   16'd300,   65, 65, $urandom,        1'b0);

    drain_requests();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** service_flap_detector: PASSED **");
    end else begin
      $display("** service_flap_detector: FAILED **");
    end
    $finish;
  end

endmodule
